// ----- src/bscc_pkg.sv -----
// Shared types for the box set collision check: wall entry and query beat.
// No dependencies; imported by bscc_cell and box_set_collision_check.
`timescale 1ns / 1ps
`default_nettype none

package bscc_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = COORD_W + 1;

    localparam int CFG_ADDR_W = 3;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_WALLS_IN_USE = 1'b0,
        REG_UNUSED       = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_WALL_WRITE = 1'b0,
        OP_QUERY      = 1'b1
    } t_opcode;

    // Wall held by one cell; far edges worked out at write time
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  bottom;
    } t_wall;

    // Query box travelling along the chain with the running hit flag
    typedef struct packed {
        logic                      last;
        logic                      hit;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  bottom;
    } t_query;

endpackage

`default_nettype wire

// ----- src/box_set_collision_check.sv -----
// Top level of the box set collision check: command port, APB register, wall chain.
// Depends on bscc_pkg and bscc_cell.
//
//  channel   handshake                      payload
//  -------   ---------                      -------
//  command   start & !busy                  i_opcode, i_wall_index, i_box_x/y/w/h, i_last_box
//  result    o_done (one-cycle strobe)      o_collides
//  config    psel & penable & pwrite        paddr, pwdata (walls_in_use at 0x0)
//
// A wall write is registered into its cell; busy stays low.
// A query passes one entry stage, then the chain of wall cells;
// busy drops as the result is registered, so the next beat can be taken then.
// The chain length, one cell per wall, sets how long a query takes.
// Reset clears the hit flag, walls_in_use and the chain valids; walls are undefined.
// The receiver cannot stall: o_done is high for exactly one cycle per last query.
`timescale 1ns / 1ps
`default_nettype none

module box_set_collision_check #(
    parameter int MAX_WALLS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_opcode,
    input  wire logic [3:0]                         i_wall_index,
    input  wire logic signed [bscc_pkg::COORD_W-1:0] i_box_x,
    input  wire logic signed [bscc_pkg::COORD_W-1:0] i_box_y,
    input  wire logic [bscc_pkg::SIZE_W-1:0]        i_box_w,
    input  wire logic [bscc_pkg::SIZE_W-1:0]        i_box_h,
    input  wire logic                               i_last_box,
    output logic                                    o_done,
    output logic                                    o_collides,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bscc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import bscc_pkg::*;

    logic [4:0] r_walls_in_use;
    logic       r_hit_flag;
    logic       r_busy;
    logic       r_done;
    logic       r_collides;
    logic       r_entry_valid;
    t_query     r_entry;

    logic       w_accept;
    logic       w_query_acc;
    logic       w_wall_acc;
    logic       w_cfg_wr;
    t_reg_idx   w_reg_idx;
    t_wall      w_wall;
    t_query     n_entry;
    logic       w_end_hit;

    logic   w_valid [0:MAX_WALLS];
    t_query w_query [0:MAX_WALLS];

    assign w_accept    = start & ~r_busy;
    assign w_query_acc = w_accept & (i_opcode == OP_QUERY);
    assign w_wall_acc  = w_accept & (i_opcode == OP_WALL_WRITE);

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[2]);
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_WALLS_IN_USE: prdata = {27'd0, r_walls_in_use};
            default:          prdata = 32'd0;
        endcase
    end

    // Far edges are one bit wider so the sum cannot wrap
    always_comb begin
        w_wall.x      = i_box_x;
        w_wall.y      = i_box_y;
        w_wall.right  = {i_box_x[COORD_W-1], i_box_x} + $signed({2'b00, i_box_w});
        w_wall.bottom = {i_box_y[COORD_W-1], i_box_y} + $signed({2'b00, i_box_h});
    end

    always_comb begin
        n_entry.last   = i_last_box;
        n_entry.hit    = r_hit_flag;
        n_entry.x      = w_wall.x;
        n_entry.y      = w_wall.y;
        n_entry.right  = w_wall.right;
        n_entry.bottom = w_wall.bottom;
    end

    assign w_valid[0] = r_entry_valid;
    assign w_query[0] = r_entry;

    for (genvar g = 0; g < MAX_WALLS; g++) begin : g_cell
        logic w_active;
        logic w_wr_en;

        assign w_active = (32'(g) < 32'(r_walls_in_use));
        assign w_wr_en  = w_wall_acc & (32'(g) == 32'(i_wall_index));

        bscc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_active(w_active),
            .i_wr_en (w_wr_en),
            .i_wall  (w_wall),
            .i_valid (w_valid[g]),
            .i_query (w_query[g]),
            .o_valid (w_valid[g+1]),
            .o_query (w_query[g+1])
        );
    end

    assign w_end_hit = w_query[MAX_WALLS].hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walls_in_use <= 5'd0;
            r_hit_flag     <= 1'b0;
            r_busy         <= 1'b0;
            r_done         <= 1'b0;
            r_entry_valid  <= 1'b0;
        end else begin
            r_entry_valid <= w_query_acc;
            if (w_cfg_wr && (w_reg_idx == REG_WALLS_IN_USE)) begin
                r_walls_in_use <= pwdata[4:0];
            end
            if (w_query_acc) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (w_valid[MAX_WALLS]) begin
                r_busy     <= 1'b0;
                r_done     <= w_query[MAX_WALLS].last;
                r_hit_flag <= w_query[MAX_WALLS].last ? 1'b0 : w_end_hit;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query_acc) begin
            r_entry <= n_entry;
        end
        if (w_valid[MAX_WALLS]) begin
            r_collides <= w_end_hit;
        end
    end

    assign busy       = r_busy;
    assign o_done     = r_done;
    assign o_collides = r_collides;

endmodule

`default_nettype wire

// ----- src/bscc_cell.sv -----
// One wall cell of the collision chain: stores a wall, tests the passing query.
// Depends on bscc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bscc_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_active,
    input  wire logic            i_wr_en,
    input  wire bscc_pkg::t_wall i_wall,
    input  wire logic            i_valid,
    input  wire bscc_pkg::t_query i_query,
    output logic                 o_valid,
    output bscc_pkg::t_query     o_query
);
    import bscc_pkg::*;

    t_wall  r_wall;
    logic   r_valid;
    t_query r_query;
    t_query n_query;
    logic   w_overlap;

    // Strict overlap: touching edges miss
    assign w_overlap = !((i_query.bottom <= r_wall.y) || (i_query.y >= r_wall.bottom) ||
                         (i_query.right <= r_wall.x) || (i_query.x >= r_wall.right));

    always_comb begin
        n_query     = i_query;
        n_query.hit = i_query.hit | (i_active & w_overlap);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_wall <= i_wall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query <= n_query;
    end

    assign o_valid = r_valid;
    assign o_query = r_query;

endmodule

`default_nettype wire
